// ----- design/hse_pkg.sv -----
// Package for the Huffman symbol encoder and packer: item types, the job
// record passed from lookup to packer, and fixed field widths.
// No dependencies.
package hse_pkg;

	localparam int KEY_W   = 24;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int SLOT_W  = 6;
	localparam int BYTE_W  = 8;
	localparam int PEND_W  = 7;
	localparam int CNT3_W  = 3;

	// lookup-to-packer queue
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  color_key;
		logic [SLOT_W-1:0] entry_index;
		logic [CODE_W-1:0] code_value;
		logic [LEN_W-1:0]  code_length;
		logic              last_pixel;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic              final_byte;
		logic              color_missing;
	} res_t;

	// one looked-up pixel; code already masked to its length
	typedef struct packed {
		logic              miss;
		logic              last_pixel;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  code_length;
	} job_t;

endpackage

// ----- design/hse_front.sv -----
// Front end of the encoder: accepts items, holds the code table and scans it
// for each pixel colour, then hands a job record to the queue.
// Depends on hse_pkg.
module hse_front #(
	parameter int TABLE_DEPTH  = 64,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hse_pkg::req_t req_data,
	output logic          push,
	output hse_pkg::job_t push_data,
	input  logic          q_full
);
	import hse_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [1:0]             state_q;
	logic [KEY_W-1:0]       color_q;
	logic                   last_q;
	logic [CNT_W-1:0]       issue_q;
	entry_t                 rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   chk_s1;
	job_t                   job_q;

	logic                   accept;
	logic                   load_wr;
	logic [IDX_W-1:0]       wr_addr;
	logic [LEN_W-1:0]       sat_len;
	logic                   issuing;
	logic                   found;
	logic                   miss_end;
	logic [CODE_W:0]        mask_w;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign load_wr   = accept && (req_data.req_type == REQ_LOAD)
		&& (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr   = IDX_W'(req_data.entry_index);
	assign sat_len   = (req_data.code_length > LEN_W'(MAX_CODE_LEN))
		? LEN_W'(MAX_CODE_LEN) : req_data.code_length;

	assign issuing  = (state_q == ST_SCAN) && (issue_q < CNT_W'(TABLE_DEPTH));
	assign found    = chk_s1 && valid_q[idx_s1] && (rd_s1.key == color_q);
	assign miss_end = chk_s1 && !found && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	// all-ones above bit 31 are dropped, so lengths of 32 or more keep the whole code
	assign mask_w   = ({{CODE_W{1'b0}}, 1'b1} << rd_s1.len) - {{CODE_W{1'b0}}, 1'b1};

	assign push      = (state_q == ST_PUSH) && !q_full;
	assign push_data = job_q;

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[wr_addr] <= '{key: req_data.color_key, code: req_data.code_value,
				len: sat_len};
		end
		rd_s1  <= mem[issue_q[IDX_W-1:0]];
		idx_s1 <= issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			state_q <= ST_IDLE;
			issue_q <= '0;
			chk_s1  <= 1'b0;
		end else begin
			if (load_wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			chk_s1 <= issuing && !(found || miss_end);
			unique case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					if (accept && req_data.req_type == REQ_PIXEL) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (found || miss_end) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			color_q <= req_data.color_key;
			last_q  <= req_data.last_pixel;
		end
		if (state_q == ST_SCAN && (found || miss_end)) begin
			job_q.miss        <= !found;
			job_q.last_pixel  <= last_q;
			job_q.code        <= rd_s1.code & mask_w[CODE_W-1:0];
			job_q.code_length <= rd_s1.len;
		end
	end

endmodule

// ----- design/hse_fifo.sv -----
// Short queue of job records between the table lookup and the bit packer.
// Depends on hse_pkg.
module hse_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hse_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output hse_pkg::job_t pop_data,
	output logic          empty
);
	import hse_pkg::*;

	job_t              slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/hse_packer.sv -----
// Back end of the encoder: takes job records, appends code bits to the running
// partial byte and emits one byte a cycle into the result register when free.
// Depends on hse_pkg.
module hse_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          pop,
	input  hse_pkg::job_t pop_data,
	output logic          res_valid,
	input  logic          res_stall,
	output hse_pkg::res_t res_data
);
	import hse_pkg::*;

	localparam int WIDE = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int XW   = PEND_W + WIDE;
	localparam int SH_W = $clog2(XW + 1);
	localparam int NB_W = $clog2(PEND_W + MAX_CODE_LEN + 1) > CNT3_W + 1
		? $clog2(PEND_W + MAX_CODE_LEN + 1) : CNT3_W + 1;

	logic              busy_q;
	logic              miss_q;
	logic              last_q;
	logic [XW-1:0]     acc_q;
	logic [NB_W-1:0]   nbits_q;
	logic [PEND_W-1:0] pend_q;
	logic [CNT3_W-1:0] cnt_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              out_free;
	logic              emit;
	res_t              emit_data;
	logic              finish;
	logic              shift_byte;
	logic [NB_W-1:0]   rem;
	logic [SH_W-1:0]   sh;

	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign out_free  = !out_valid_q || !res_stall;
	assign pop       = !busy_q && !q_empty;

	// code lands just below the leftover bits, the whole run left-aligned
	assign sh  = SH_W'(XW) - SH_W'(cnt_q) - SH_W'(pop_data.code_length);
	assign rem = nbits_q - NB_W'(BYTE_W);

	always_comb begin
		emit       = 1'b0;
		finish     = 1'b0;
		shift_byte = 1'b0;
		emit_data  = '{out_byte: acc_q[XW-1 -: BYTE_W], last_of_run: 1'b0,
			final_byte: 1'b0, color_missing: 1'b0};
		if (busy_q && out_free) begin
			priority if (miss_q) begin
				emit      = 1'b1;
				finish    = 1'b1;
				emit_data = '{out_byte: '0, last_of_run: 1'b1, final_byte: 1'b0,
					color_missing: 1'b1};
			end else if (nbits_q >= NB_W'(BYTE_W)) begin
				emit       = 1'b1;
				shift_byte = 1'b1;
				emit_data.last_of_run = (rem < NB_W'(BYTE_W)) && !(last_q && rem != '0);
			end else begin
				finish = 1'b1;
				if (last_q && nbits_q != '0) begin
					emit                  = 1'b1;
					emit_data.last_of_run = 1'b1;
					emit_data.final_byte  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			// a found pixel keeps its leftover bits unless it was the last; a miss leaves them untouched
			if (finish && !miss_q) begin
				pend_q <= last_q ? '0 : acc_q[XW-1 -: PEND_W];
				cnt_q  <= last_q ? '0 : nbits_q[CNT3_W-1:0];
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			miss_q  <= pop_data.miss;
			last_q  <= pop_data.last_pixel;
			acc_q   <= {pend_q, {(XW - PEND_W){1'b0}}} | (XW'(pop_data.code) << sh);
			nbits_q <= NB_W'(cnt_q) + NB_W'(pop_data.code_length);
		end else if (shift_byte) begin
			acc_q   <= acc_q << BYTE_W;
			nbits_q <= rem;
		end
		if (out_free && emit) begin
			out_q <= emit_data;
		end
	end

endmodule

// ----- design/huffman_symbol_encoder_packer.sv -----
// Huffman symbol encoder and bit packer. A load item writes a table slot and leaves
// the request side free. A pixel item holds the request side while the table memory
// is scanned one slot a cycle from slot zero through the single table read port;
// the request side is freed once the pixel's job record, hit or miss, enters the
// queue, so a full queue keeps it held. The packer behind a two-entry queue loads
// each job record and, while the result register is free, emits its full bytes one
// a cycle (up to five per pixel, counting the closing byte), then closes the pixel,
// where the padded closing byte of a last pixel leaves. It keeps working while the
// next pixel is looked up. Results wait in an output register until taken.
// Depends on hse_pkg, hse_front, hse_fifo, hse_packer.
module huffman_symbol_encoder_packer #(
	parameter int TABLE_DEPTH  = 64,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hse_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output hse_pkg::res_t res_data
);
	import hse_pkg::*;

	logic q_push;
	job_t q_push_data;
	logic q_full;
	logic q_pop;
	job_t q_pop_data;
	logic q_empty;

	hse_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.push     (q_push),
		.push_data(q_push_data),
		.q_full   (q_full)
	);

	hse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	hse_packer #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

// ----- design/hse_checker.sv -----
// Port-level checks for the Huffman symbol encoder and packer, bound to the top.
// Depends on hse_pkg and huffman_symbol_encoder_packer.
module hse_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input hse_pkg::req_t req_data,
	input logic          res_valid,
	input logic          res_stall,
	input hse_pkg::res_t res_data
);
	import hse_pkg::*;

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_miss_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.color_missing |->
			res_data.last_of_run && !res_data.final_byte && res_data.out_byte == '0)
		else $error("missing-colour result malformed");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.final_byte |->
			res_data.last_of_run && !res_data.color_missing)
		else $error("closing byte not last of run");

	// a pixel starts a table scan, so the next item must wait
	a_pixel_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.req_type == REQ_PIXEL |=> req_stall)
		else $error("pixel accepted without scan");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.req_type == REQ_LOAD |=> !req_stall)
		else $error("table load held request side");

endmodule

bind huffman_symbol_encoder_packer hse_checker u_hse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req_data (req_data),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

// ----- sim/tb_huffman_symbol_encoder_packer.sv -----
// Testbench for the Huffman symbol encoder and bit packer: drives table loads and pixels,
// predicts every packed byte and checks each one as it is taken.
// Depends on hse_pkg and huffman_symbol_encoder_packer.
module tb_huffman_symbol_encoder_packer;
	import hse_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int MAX_CODE_LEN = 32;
	localparam int QUIET_LIMIT  = 4000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	// table and packer state as the block should hold it
	logic [KEY_W-1:0]  slot_key  [TABLE_DEPTH];
	logic [CODE_W-1:0] slot_code [TABLE_DEPTH];
	int                slot_len  [TABLE_DEPTH];
	bit                slot_live [TABLE_DEPTH];
	logic [PEND_W-1:0] carry_bits = '0;
	int                carry_cnt  = 0;

	res_t due_bytes [$];
	res_t want_res;
	int   mismatches      = 0;
	int   quiet_cycles    = 0;
	int   hold_off_cycles = 0;
	bit   no_gaps         = 1'b0;

	huffman_symbol_encoder_packer #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	always #6 clk = ~clk;

	function automatic void encode_item(input req_t r);
		int          hit;
		int          clen;
		int          nbits;
		int          total;
		int          k;
		logic [63:0] acc;
		logic [63:0] cbits;
		res_t        e;
		hit = -1;
		if (r.req_type == REQ_LOAD) begin
			if (int'(r.entry_index) < TABLE_DEPTH) begin
				slot_key[r.entry_index]  = r.color_key;
				slot_code[r.entry_index] = r.code_value;
				slot_len[r.entry_index]  = (r.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN
					: int'(r.code_length);
				slot_live[r.entry_index] = 1'b1;
			end
			return;
		end
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (hit < 0 && slot_live[i] && slot_key[i] == r.color_key)
				hit = i;
		if (hit < 0) begin
			// unknown colour: one flagged item, packer untouched
			e = '{out_byte: '0, last_of_run: 1'b1, final_byte: 1'b0, color_missing: 1'b1};
			due_bytes.insert(due_bytes.size(), e);
			return;
		end
		clen  = slot_len[hit];
		cbits = {32'b0, slot_code[hit]} & ((64'd1 << clen) - 64'd1);
		acc   = ({57'b0, carry_bits} << clen) | cbits;
		nbits = carry_cnt + clen;
		total = nbits / 8 + ((r.last_pixel && (nbits % 8) != 0) ? 1 : 0);
		k     = 0;
		e     = '0;
		while (nbits >= 8) begin
			nbits         = nbits - 8;
			e.out_byte    = acc[nbits +: 8];
			e.last_of_run = (k == total - 1);
			due_bytes.insert(due_bytes.size(), e);
			k++;
		end
		if (r.last_pixel) begin
			if (nbits > 0) begin
				e.out_byte    = 8'(acc << (8 - nbits));
				e.last_of_run = 1'b1;
				e.final_byte  = 1'b1;
				due_bytes.insert(due_bytes.size(), e);
			end
			carry_bits = '0;
			carry_cnt  = 0;
		end else begin
			carry_bits = 7'(acc & ((64'd1 << nbits) - 64'd1));
			carry_cnt  = nbits;
		end
	endfunction

	function automatic logic [KEY_W-1:0] known_color();
		int start;
		start = $urandom_range(TABLE_DEPTH - 1);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_live[(start + i) % TABLE_DEPTH])
				return slot_key[(start + i) % TABLE_DEPTH];
		return KEY_W'($urandom);
	endfunction

	function automatic req_t load_req(input int slot, input logic [KEY_W-1:0] key,
		input logic [CODE_W-1:0] code, input int len);
		req_t r;
		r.req_type    = REQ_LOAD;
		r.color_key   = key;
		r.entry_index = SLOT_W'(slot);
		r.code_value  = code;
		r.code_length = LEN_W'(len);
		r.last_pixel  = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic req_t pixel_req(input logic [KEY_W-1:0] key, input logic last);
		req_t r;
		r.req_type    = REQ_PIXEL;
		r.color_key   = key;
		r.entry_index = SLOT_W'($urandom);
		r.code_value  = $urandom;
		r.code_length = LEN_W'($urandom);
		r.last_pixel  = last;
		return r;
	endfunction

	function automatic req_t random_item(input int load_pct);
		req_t r;
		int   roll;
		r.req_type    = ($urandom_range(99) < load_pct) ? REQ_LOAD : REQ_PIXEL;
		r.entry_index = SLOT_W'($urandom);
		r.code_value  = $urandom;
		r.last_pixel  = ($urandom_range(5) == 0);
		roll = $urandom_range(99);
		if (roll < 5)
			r.code_length = '0;
		else if (roll < 10)
			r.code_length = LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63));
		else if (roll < 25)
			r.code_length = LEN_W'($urandom_range(13, MAX_CODE_LEN));
		else
			r.code_length = LEN_W'($urandom_range(1, 12));
		roll = $urandom_range(99);
		if (r.req_type == REQ_LOAD)
			r.color_key = (roll < 10) ? known_color() : KEY_W'($urandom);
		else
			r.color_key = (roll < 85) ? known_color() : KEY_W'($urandom);
		return r;
	endfunction

	// offer one item after a random gap and hold it until taken
	task automatic send_item(input req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data  <= r;
		req_valid <= 1'b1;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		encode_item(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic test_directed_cases();
		send_item(load_req(0, 24'h000000, 32'h0000_0001, 1));
		send_item(load_req(TABLE_DEPTH - 1, 24'hFF_FFFF, 32'hFFFF_FFFF, MAX_CODE_LEN));
		send_item(load_req(5, 24'h12_3456, 32'hDEAD_BEEF, 0));
		send_item(load_req(6, 24'hAB_CDEF, 32'h8000_0001, 63));
		send_item(load_req(10, 24'h00_FF00, 32'hF0F0_F0F5, 3));
		send_item(load_req(11, 24'h00_FF00, 32'h0000_0000, 5));
		send_item(pixel_req(24'hFF_FFFF, 1'b0));
		// build up seven leftover bits, then flush the widest code on top
		send_item(pixel_req(24'h00_0000, 1'b0));
		send_item(pixel_req(24'h00_FF00, 1'b0));
		send_item(pixel_req(24'h00_FF00, 1'b0));
		send_item(pixel_req(24'hFF_FFFF, 1'b1));
		send_item(pixel_req(24'h12_3456, 1'b0));
		send_item(pixel_req(24'h12_3456, 1'b1));
		send_item(pixel_req(24'h77_7777, 1'b1));
		send_item(pixel_req(24'hAB_CDEF, 1'b1));
		send_item(pixel_req(24'h00_0000, 1'b0));
		send_item(pixel_req(24'h12_3456, 1'b1));
		send_item(load_req(0, 24'h00_0001, 32'h0000_00A5, 8));
		send_item(pixel_req(24'h00_0001, 1'b1));
		send_item(pixel_req(24'h00_0000, 1'b0));
		send_item(pixel_req(24'h00_0000, 1'b1));
		wait_drained();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_item(random_item(25));
	endtask

	task automatic test_pause_for_results();
		repeat (2) begin
			repeat (12)
				send_item(random_item(15));
			wait_drained();
		end
	endtask

	task automatic test_output_hold();
		no_gaps         = 1'b1;
		hold_off_cycles = 600;
		repeat (24)
			send_item(random_item(0));
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (40)
			send_item(random_item(20));
		no_gaps = 1'b0;
		wait_drained();
	endtask

	// receiver: random stall before each item, or one long hold on request
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 4);
			if (hold_off_cycles > 0) begin
				gap             = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			do
				@(negedge clk);
			while (!res_valid && hold_off_cycles == 0);
			@(posedge clk);
		end
	end

	// inputs settle at the rising edge, so sample at the falling edge
	always @(negedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_bytes.size() == 0) begin
				$display("%0t: unexpected item, expected none got %0h", $time, res_data);
				mismatches++;
			end else begin
				want_res = due_bytes.pop_front();
				check_field("out_byte", want_res.out_byte, res_data.out_byte);
				check_field("last_of_run", want_res.last_of_run, res_data.last_of_run);
				check_field("final_byte", want_res.final_byte, res_data.final_byte);
				check_field("color_missing", want_res.color_missing, res_data.color_missing);
			end
		end
	end

	always @(negedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_huffman_symbol_encoder_packer: errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			slot_live[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_mix(110);
		test_pause_for_results();
		test_output_hold();
		test_random_mix(110);
		test_back_to_back();
		wait_drained();
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (mismatches == 0 && due_bytes.size() == 0)
			$display("tb_huffman_symbol_encoder_packer: clean");
		else
			$display("tb_huffman_symbol_encoder_packer: errors");
		$finish;
	end

endmodule

// ----- huffman_symbol_encoder_packer.f -----
design/hse_pkg.sv
design/hse_front.sv
design/hse_fifo.sv
design/hse_packer.sv
design/huffman_symbol_encoder_packer.sv
design/hse_checker.sv
sim/tb_huffman_symbol_encoder_packer.sv
